FILE: rtl/core/sqfc_pkg.sv
`default_nettype none

package sqfc_pkg;

    localparam int CMD_W      = 2;
    localparam int PTR_W      = 16;
    localparam int ID_W       = 16;
    localparam int SIZE_W     = 17;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [SIZE_W-1:0] SIZE_MIN     = 17'd2;
    localparam logic [SIZE_W-1:0] SIZE_MAX     = 17'd65536;
    localparam logic [SIZE_W-1:0] SQ_DEPTH_RST = 17'd32;
    localparam logic [PTR_W-1:0]  FC_OFF_HEAD  = 16'hFFFF;
    localparam logic [ID_W-1:0]   ID_SKIP      = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_SQ_DEPTH    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FC_REQUIRED = 1'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_CONNECT  = 2'd0,
        CMD_SUBMIT   = 2'd1,
        CMD_RESPONSE = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_REFUSED = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd              cmd;
        logic [PTR_W-1:0]  reported_head;
        logic              head_valid;
    } t_item;

    typedef struct packed {
        t_status           status;
        logic [ID_W-1:0]   command_id;
        logic [PTR_W-1:0]  head_now;
        logic [PTR_W-1:0]  tail_now;
        logic              fc_on;
        logic              queue_idle;
    } t_result;

    typedef struct packed {
        logic [SIZE_W-1:0] size_eff;
        logic              fc_required;
    } t_cfg;

endpackage

`default_nettype wire

FILE: rtl/core/sqfc_if.sv
`default_nettype none

interface sqfc_in_if;
    logic                          valid;
    logic                          ready;
    logic [sqfc_pkg::CMD_W-1:0]    cmd;
    logic [sqfc_pkg::PTR_W-1:0]    reported_head;
    logic                          head_valid;

    modport source (output valid, cmd, reported_head, head_valid, input ready);
    modport sink   (input valid, cmd, reported_head, head_valid, output ready);
endinterface

interface sqfc_out_if;
    logic                          valid;
    logic                          ready;
    logic [sqfc_pkg::STATUS_W-1:0] status;
    logic [sqfc_pkg::ID_W-1:0]     command_id;
    logic [sqfc_pkg::PTR_W-1:0]    head_now;
    logic [sqfc_pkg::PTR_W-1:0]    tail_now;
    logic                          fc_on;
    logic                          queue_idle;

    modport source (output valid, status, command_id, head_now, tail_now, fc_on,
                    queue_idle, input ready);
    modport sink   (input valid, status, command_id, head_now, tail_now, fc_on,
                    queue_idle, output ready);
endinterface

interface sqfc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sqfc_pkg::CFG_IDX_W-1:0]  index;
    logic [sqfc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sq_flow_control_tracker.sv
// Channel  Dir  Modport  Payload
// i_sub    in   sink     cmd, reported_head, head_valid
// o_res    out  source   status, command_id, head_now, tail_now, fc_on, queue_idle
// i_cfg    in   sink     index (0 sq depth, 1 fc_required), data
//
// One beat per cycle sustained while results are taken; a beat taken into the input
// register moves into the result register once that is free, and is offered from there.
// i_rst_n is synchronous: pointers, command ID and flow control clear,
// sq depth returns to 32 and fc_required to 1. No clearing pass.
// A stalled result holds; a new beat is still taken while the input stage is
// empty or moving into a free result register.
`default_nettype none

module sq_flow_control_tracker (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sqfc_in_if.sink    i_sub,
    sqfc_out_if.source o_res,
    sqfc_cfg_if.sink   i_cfg
);
    import sqfc_pkg::*;

    t_cfg    w_cfg;
    t_result w_res;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    w_out_free;
    logic    w_step;

    sqfc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    sqfc_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_step  (w_step),
        .i_item  (r_in),
        .o_res   (w_res)
    );

    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_step      = r_in_valid && w_out_free;
    assign i_sub.ready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_sub.ready) begin
                r_in_valid <= i_sub.valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sub.valid && i_sub.ready) begin
            r_in.cmd           <= t_cmd'(i_sub.cmd);
            r_in.reported_head <= i_sub.reported_head;
            r_in.head_valid    <= i_sub.head_valid;
        end
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_out.status;
    assign o_res.command_id = r_out.command_id;
    assign o_res.head_now   = r_out.head_now;
    assign o_res.tail_now   = r_out.tail_now;
    assign o_res.fc_on      = r_out.fc_on;
    assign o_res.queue_idle = r_out.queue_idle;

endmodule

`default_nettype wire

FILE: rtl/core/sqfc_cfg.sv
`default_nettype none

module sqfc_cfg (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    sqfc_cfg_if.sink       i_cfg,
    output sqfc_pkg::t_cfg o_cfg
);
    import sqfc_pkg::*;

    logic [SIZE_W-1:0] r_sq_depth;
    logic              r_fc_required;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_depth    <= SQ_DEPTH_RST;
            r_fc_required <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SQ_DEPTH:    r_sq_depth    <= i_cfg.data[SIZE_W-1:0];
                CFG_FC_REQUIRED: r_fc_required <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // clamp into the legal queue range
    always_comb begin
        if (r_sq_depth < SIZE_MIN) begin
            o_cfg.size_eff = SIZE_MIN;
        end else if (r_sq_depth > SIZE_MAX) begin
            o_cfg.size_eff = SIZE_MAX;
        end else begin
            o_cfg.size_eff = r_sq_depth;
        end
        o_cfg.fc_required = r_fc_required;
    end

endmodule

`default_nettype wire

FILE: rtl/core/sqfc_state.sv
`default_nettype none

module sqfc_state (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sqfc_pkg::t_cfg  i_cfg,
    input  wire logic            i_step,
    input  wire sqfc_pkg::t_item i_item,
    output sqfc_pkg::t_result    o_res
);
    import sqfc_pkg::*;

    logic [PTR_W-1:0]  r_head_ptr, n_head_ptr;
    logic [PTR_W-1:0]  r_tail_ptr, n_tail_ptr;
    logic [ID_W-1:0]   r_next_id,  n_next_id;
    logic              r_fc_active, n_fc_active;
    logic [PTR_W-1:0]  w_tail_inc;
    logic [PTR_W-1:0]  w_head_inc;
    logic [ID_W-1:0]   w_id_inc;
    t_status           w_status;
    logic [ID_W-1:0]   w_cid;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p,
                                                  input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] n;
        n = {1'b0, p} + 1'b1;
        return (n >= size) ? '0 : n[PTR_W-1:0];
    endfunction

    assign w_tail_inc = wrap_inc(r_tail_ptr, i_cfg.size_eff);
    assign w_head_inc = wrap_inc(r_head_ptr, i_cfg.size_eff);
    assign w_id_inc   = r_next_id + 1'b1;

    always_comb begin
        n_head_ptr  = r_head_ptr;
        n_tail_ptr  = r_tail_ptr;
        n_next_id   = r_next_id;
        n_fc_active = r_fc_active;
        w_status    = ST_OK;
        w_cid       = '0;
        case (i_item.cmd)
            CMD_CONNECT: begin
                if (!i_item.head_valid) begin
                    w_status = ST_REFUSED;
                end else if (i_item.reported_head == FC_OFF_HEAD) begin
                    if (i_cfg.fc_required) begin
                        w_status = ST_REFUSED;
                    end else begin
                        n_fc_active = 1'b0;
                    end
                end else begin
                    n_fc_active = 1'b1;
                    n_head_ptr  = i_item.reported_head;
                    n_tail_ptr  = i_item.reported_head;
                end
            end
            CMD_SUBMIT: begin
                if (w_tail_inc == r_head_ptr) begin
                    w_status = ST_FULL;
                end else begin
                    w_cid      = r_next_id;
                    n_next_id  = (w_id_inc == ID_SKIP) ? '0 : w_id_inc;
                    n_tail_ptr = w_tail_inc;
                end
            end
            CMD_RESPONSE: begin
                if (r_head_ptr == r_tail_ptr) begin
                    w_status = ST_EMPTY;
                end else if (r_fc_active) begin
                    if (i_item.head_valid) begin
                        n_head_ptr = i_item.reported_head;
                    end
                end else begin
                    n_head_ptr = w_head_inc;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_ptr  <= '0;
            r_tail_ptr  <= '0;
            r_next_id   <= '0;
            r_fc_active <= 1'b0;
        end else if (i_step) begin
            r_head_ptr  <= n_head_ptr;
            r_tail_ptr  <= n_tail_ptr;
            r_next_id   <= n_next_id;
            r_fc_active <= n_fc_active;
        end
    end

    always_comb begin
        o_res.status     = w_status;
        o_res.command_id = w_cid;
        o_res.head_now   = n_head_ptr;
        o_res.tail_now   = n_tail_ptr;
        o_res.fc_on      = n_fc_active;
        o_res.queue_idle = (n_head_ptr == n_tail_ptr);
    end

    a_id_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_id != ID_SKIP)
        else $error("next command ID reached the reserved value");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_head_ptr) && $stable(r_tail_ptr) && $stable(r_next_id)
                    && $stable(r_fc_active))
        else $error("state moved without a beat");

    a_submit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.cmd == CMD_SUBMIT && w_status == ST_OK)
        |=> r_head_ptr != r_tail_ptr && $stable(r_head_ptr))
        else $error("accepted submit left queue idle or moved head");

    a_fc_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.cmd == CMD_CONNECT && i_cfg.fc_required
         && i_item.reported_head == FC_OFF_HEAD) |-> w_status == ST_REFUSED)
        else $error("flow control disable not refused");

    a_refuse_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && w_status != ST_OK) |=> $stable(r_head_ptr) && $stable(r_tail_ptr)
                                          && $stable(r_next_id))
        else $error("refused beat changed the pointers");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import sqfc_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int HOLD_CYCLES = 400;

    localparam int PRESS_NONE  = 0;
    localparam int PRESS_HOLD  = 1;
    localparam int PRESS_PAUSE = 2;

    class sq_scoreboard;
        logic [SIZE_W-1:0] size_reg;
        logic              fc_req;
        logic [PTR_W-1:0]  head;
        logic [PTR_W-1:0]  tail;
        logic [ID_W-1:0]   next_cid;
        logic              fc_act;
        t_result           pending[$];
        int                errors;

        function new();
            size_reg = SQ_DEPTH_RST;
            fc_req   = 1'b1;
            head     = '0;
            tail     = '0;
            next_cid = '0;
            fc_act   = 1'b0;
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_SQ_DEPTH) begin
                size_reg = val[SIZE_W-1:0];
            end else if (idx == CFG_FC_REQUIRED) begin
                fc_req = val[0];
            end
        endfunction

        function int unsigned qsize();
            if (size_reg < SIZE_MIN) return SIZE_MIN;
            if (size_reg > SIZE_MAX) return SIZE_MAX;
            return size_reg;
        endfunction

        function logic [PTR_W-1:0] step_ptr(logic [PTR_W-1:0] p);
            int unsigned n;
            n = p + 1;
            if (n >= qsize()) n = 0;
            return n[PTR_W-1:0];
        endfunction

        task report(string msg);
            errors++;
            $display("tb_top: mismatch: %s", msg);
        endtask

        function void note_beat(t_item it);
            t_result          r;
            logic [PTR_W-1:0] nt;
            r = '0;
            r.status = ST_OK;
            case (it.cmd)
                CMD_CONNECT: begin
                    if (!it.head_valid) begin
                        r.status = ST_REFUSED;
                    end else if (it.reported_head == FC_OFF_HEAD) begin
                        if (fc_req) r.status = ST_REFUSED;
                        else fc_act = 1'b0;
                    end else begin
                        fc_act = 1'b1;
                        head   = it.reported_head;
                        tail   = it.reported_head;
                    end
                end
                CMD_SUBMIT: begin
                    nt = step_ptr(tail);
                    if (nt == head) begin
                        r.status = ST_FULL;
                    end else begin
                        r.command_id = next_cid;
                        next_cid = next_cid + 1'b1;
                        if (next_cid == ID_SKIP) next_cid = '0;
                        tail = nt;
                    end
                end
                CMD_RESPONSE: begin
                    if (head == tail) begin
                        r.status = ST_EMPTY;
                    end else if (fc_act) begin
                        if (it.head_valid) head = it.reported_head;
                    end else begin
                        head = step_ptr(head);
                    end
                end
                default: ;
            endcase
            r.head_now   = head;
            r.tail_now   = tail;
            r.fc_on      = fc_act;
            r.queue_idle = (head == tail);
            pending.push_back(r);
        endfunction

        task cmp(string field, int unsigned got, int unsigned want);
            if (got != want) report($sformatf("%s got %0h want %0h", field, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                report("result beat with nothing outstanding");
                return;
            end
            want = pending.pop_front();
            cmp("status", got.status, want.status);
            cmp("command_id", got.command_id, want.command_id);
            cmp("head_now", got.head_now, want.head_now);
            cmp("tail_now", got.tail_now, want.tail_now);
            cmp("fc_on", got.fc_on, want.fc_on);
            cmp("queue_idle", got.queue_idle, want.queue_idle);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    sqfc_in_if  sub_if ();
    sqfc_out_if res_if ();
    sqfc_cfg_if cfg_if ();

    sq_flow_control_tracker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sub   (sub_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    sq_scoreboard sb;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_len      = 0;
    int cycle_count   = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_top: FAIL");
        $finish;
    end

    // result sink: random stalls, plus long hold-offs on request
    initial begin : sink_proc
        int hold;
        hold = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_len != 0) begin
                hold = hold_len;
                hold_len = 0;
            end
            if (hold > 0) begin
                hold--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_item   it;
        t_result rs;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
            if (sub_if.valid && sub_if.ready) begin
                it.cmd           = t_cmd'(sub_if.cmd);
                it.reported_head = sub_if.reported_head;
                it.head_valid    = sub_if.head_valid;
                sb.note_beat(it);
            end
            if (res_if.valid && res_if.ready) begin
                rs.status     = t_status'(res_if.status);
                rs.command_id = res_if.command_id;
                rs.head_now   = res_if.head_now;
                rs.tail_now   = res_if.tail_now;
                rs.fc_on      = res_if.fc_on;
                rs.queue_idle = res_if.queue_idle;
                sb.check_result(rs);
            end
        end
    end

    function automatic t_item beat(t_cmd c, logic [PTR_W-1:0] h, logic v);
        t_item it;
        it.cmd           = c;
        it.reported_head = h;
        it.head_valid    = v;
        return it;
    endfunction

    function automatic t_item make_item();
        t_item       it;
        int unsigned pick;
        int unsigned lim;
        int unsigned span;
        int unsigned step;
        lim = sb.qsize();
        it.head_valid    = 1'b1;
        it.reported_head = 16'($urandom_range(16'hFFFF));
        pick = $urandom_range(99);
        if (pick < 8) begin
            it.cmd = CMD_CONNECT;
            pick = $urandom_range(99);
            if (pick < 15) it.head_valid = 1'b0;
            else if (pick < 40) it.reported_head = FC_OFF_HEAD;
            else if (pick < 80) it.reported_head = 16'($urandom_range(lim - 1));
        end else if (pick < 53) begin
            it.cmd = CMD_SUBMIT;
            it.head_valid = 1'($urandom_range(1));
        end else if (pick < 97) begin
            it.cmd = CMD_RESPONSE;
            it.head_valid = ($urandom_range(99) < 85);
            // well-formed: move the head forward over outstanding entries
            if (it.head_valid && $urandom_range(99) < 90 && sb.head < lim && sb.tail < lim) begin
                span = (sb.tail + lim - sb.head) % lim;
                step = (span == 0) ? 0 : $urandom_range(span, 1);
                it.reported_head = 16'((sb.head + step) % lim);
            end
        end else begin
            it.cmd = t_cmd'(CMD_UNUSED);
            it.head_valid = 1'($urandom_range(1));
        end
        return it;
    endfunction

    task automatic send(input t_item it);
        while ($urandom_range(99) < src_idle_pct) begin
            sub_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        sub_if.valid         <= 1'b1;
        sub_if.cmd           <= it.cmd;
        sub_if.reported_head <= it.reported_head;
        sub_if.head_valid    <= it.head_valid;
        @(posedge i_clk);
        while (!sub_if.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        sub_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] size, input logic fcr);
        drain();
        write_reg(CFG_SQ_DEPTH, size);
        write_reg(CFG_FC_REQUIRED, {{(CFG_DATA_W-1){1'b0}}, fcr});
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] size, input logic fcr,
                             input int src_pct, input int snk_pct,
                             input int n_items, input int press);
        t_item it;
        int    done;
        bit    pressed;
        done    = 0;
        pressed = 1'b0;
        set_config(size, fcr);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        while (done < n_items) begin
            if (!pressed && done >= n_items / 3 && press == PRESS_HOLD) begin
                hold_len = HOLD_CYCLES;
                pressed  = 1'b1;
            end
            if (!pressed && done >= n_items / 2 && press == PRESS_PAUSE) begin
                drain();
                pressed = 1'b1;
            end
            it = make_item();
            send(it);
            if (it.cmd != CMD_UNUSED) done++;
        end
    endtask

    initial begin : main_proc
        int n;
        sb = new();
        i_rst_n              <= 1'b0;
        sub_if.valid         <= 1'b0;
        sub_if.cmd           <= CMD_CONNECT;
        sub_if.reported_head <= '0;
        sub_if.head_valid    <= 1'b0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= CFG_SQ_DEPTH;
        cfg_if.data          <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset configuration
        send(beat(CMD_RESPONSE, 16'h0000, 1'b1));
        send(beat(CMD_SUBMIT, 16'hFFFF, 1'b0));
        send(beat(CMD_RESPONSE, 16'h0000, 1'b0));
        send(beat(CMD_CONNECT, 16'h0003, 1'b0));
        send(beat(CMD_CONNECT, FC_OFF_HEAD, 1'b1));
        send(beat(CMD_CONNECT, 16'h0000, 1'b1));
        send(beat(CMD_CONNECT, 16'hFFFE, 1'b1));
        send(beat(CMD_SUBMIT, 16'h0000, 1'b1));
        send(beat(CMD_RESPONSE, 16'hFFFF, 1'b1));
        send(beat(CMD_SUBMIT, 16'h0000, 1'b0));
        send(beat(CMD_RESPONSE, 16'h1234, 1'b0));
        send(beat(CMD_RESPONSE, 16'h0001, 1'b1));
        send(beat(CMD_RESPONSE, 16'h0001, 1'b1));
        send(beat(t_cmd'(CMD_UNUSED), 16'hFFFF, 1'b1));
        send(beat(CMD_CONNECT, 16'd30, 1'b1));
        send(beat(CMD_SUBMIT, 16'h0000, 1'b1));
        send(beat(CMD_SUBMIT, 16'h0000, 1'b1));
        send(beat(CMD_RESPONSE, 16'h0000, 1'b1));

        // directed, smallest queue, flow control may be dropped
        set_config(17'd2, 1'b0);
        send(beat(CMD_CONNECT, FC_OFF_HEAD, 1'b1));
        send(beat(CMD_SUBMIT, 16'h0000, 1'b1));
        send(beat(CMD_SUBMIT, 16'h0000, 1'b1));
        send(beat(CMD_RESPONSE, 16'h0000, 1'b1));

        // directed, oversized setting clamps to the largest queue
        set_config(17'h1FFFF, 1'b1);
        send(beat(CMD_CONNECT, 16'hFFFE, 1'b1));
        send(beat(CMD_SUBMIT, 16'h0000, 1'b1));
        send(beat(CMD_SUBMIT, 16'h0000, 1'b1));
        send(beat(CMD_RESPONSE, 16'h0000, 1'b1));

        run_phase(17'd4,      1'b0, 0,  0,  250, PRESS_NONE);
        run_phase(17'd0,      1'b1, 68, 0,  200, PRESS_NONE);
        run_phase(SIZE_MAX,   1'b0, 0,  68, 250, PRESS_PAUSE);
        run_phase(17'd1,      1'b0, 18, 18, 200, PRESS_NONE);
        run_phase(17'h1FFFF,  1'b1, 0,  0,  200, PRESS_HOLD);
        run_phase(17'd3,      1'b0, 18, 18, 250, PRESS_HOLD);
        run_phase(17'd32,     1'b1, 68, 68, 200, PRESS_NONE);

        // fill a mid-sized queue back to back until submits are refused
        set_config(17'd64, 1'b1);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send(beat(CMD_CONNECT, 16'h0000, 1'b1));
        for (n = 0; n < 100; n++) send(beat(CMD_SUBMIT, 16'h0000, 1'b1));
        send(beat(CMD_CONNECT, 16'h0000, 1'b1));
        for (n = 0; n < 8; n++) begin
            send(beat(CMD_SUBMIT, 16'h0000, 1'b1));
            send(beat(CMD_RESPONSE, 16'h0001, 1'b1));
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
